/* sv/qdec_pkg.sv */
// Shared types and constants for the multi-knob quadrature decoder.
// Holds the request/response item structs and the AB transition table.
// No dependencies.
package qdec_pkg;

   localparam int KNOB_W = 2;
   localparam int DATA_W = 32;
   localparam int MASK_W = 8;

   // Transition codes
   localparam logic [1:0] TR_NONE = 2'd0;
   localparam logic [1:0] TR_FWD  = 2'd1;
   localparam logic [1:0] TR_BACK = 2'd2;
   localparam logic [1:0] TR_BAD  = 2'd3;

   localparam logic [1:0] AB_RESET = 2'b11;

   typedef struct packed {
      logic [KNOB_W-1:0] knob;
      logic              level_a;
      logic              level_b;
      logic [DATA_W-1:0] time_us;
   } req_type;

   typedef struct packed {
      logic signed [1:0]        step;
      logic                     invalid;
      logic signed [DATA_W-1:0] position;
      logic [DATA_W-1:0]        reject_count;
      logic [DATA_W-1:0]        last_edge_time;
   } rsp_type;

   // Old AB in the high bits, new AB in the low bits.
   function automatic logic [1:0] trans_code(input logic [1:0] old_ab,
                                             input logic [1:0] new_ab);
      logic [1:0] code;
      case ({old_ab, new_ab})
         4'b0000: code = TR_NONE;
         4'b0001: code = TR_FWD;
         4'b0010: code = TR_BACK;
         4'b0011: code = TR_BAD;
         4'b0100: code = TR_BACK;
         4'b0101: code = TR_NONE;
         4'b0110: code = TR_BAD;
         4'b0111: code = TR_FWD;
         4'b1000: code = TR_FWD;
         4'b1001: code = TR_BAD;
         4'b1010: code = TR_NONE;
         4'b1011: code = TR_BACK;
         4'b1100: code = TR_BAD;
         4'b1101: code = TR_BACK;
         4'b1110: code = TR_FWD;
         4'b1111: code = TR_NONE;
         default: code = TR_NONE;
      endcase
      return code;
   endfunction

endpackage

/* sv/qdec_core.sv */
// Per-knob state registers and the combinational decode/update logic.
// Depends on qdec_pkg.
module qdec_core #(
   parameter int KNOBS = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  qdec_pkg::req_type       item,
   input  logic [qdec_pkg::MASK_W-1:0] reverse_mask,
   output qdec_pkg::rsp_type       result
);
   import qdec_pkg::*;

   logic [1:0]        ab_ff    [KNOBS];
   logic [1:0]        ab_in    [KNOBS];
   logic [DATA_W-1:0] total_ff [KNOBS];
   logic [DATA_W-1:0] total_in [KNOBS];
   logic [DATA_W-1:0] tally_ff [KNOBS];
   logic [DATA_W-1:0] tally_in [KNOBS];
   logic [DATA_W-1:0] stamp_ff [KNOBS];
   logic [DATA_W-1:0] stamp_in [KNOBS];

   logic [KNOBS-1:0]  hit;
   logic              in_range;
   logic [1:0]        old_ab;
   logic [1:0]        now_ab;
   logic [DATA_W-1:0] cur_total;
   logic [DATA_W-1:0] cur_tally;
   logic [DATA_W-1:0] cur_stamp;
   logic [1:0]        code;
   logic              bad;
   logic              moving;
   logic              up;
   logic [DATA_W-1:0] nxt_total;
   logic [DATA_W-1:0] nxt_tally;
   logic [DATA_W-1:0] nxt_stamp;

   // Select the addressed knob's state
   always_comb begin
      old_ab    = '0;
      cur_total = '0;
      cur_tally = '0;
      cur_stamp = '0;
      for (int k = 0; k < KNOBS; k++) begin
         hit[k] = ({{(DATA_W-KNOB_W){1'b0}}, item.knob} == DATA_W'(k));
         old_ab    = old_ab    | (ab_ff[k]    & {2{hit[k]}});
         cur_total = cur_total | (total_ff[k] & {DATA_W{hit[k]}});
         cur_tally = cur_tally | (tally_ff[k] & {DATA_W{hit[k]}});
         cur_stamp = cur_stamp | (stamp_ff[k] & {DATA_W{hit[k]}});
      end
      in_range = |hit;
   end

   assign now_ab    = {item.level_a, item.level_b};
   assign code      = trans_code(old_ab, now_ab);
   assign bad       = (code == TR_BAD);
   assign moving    = (code == TR_FWD) || (code == TR_BACK);
   assign up        = (code == TR_FWD) ^ reverse_mask[{1'b0, item.knob}];
   // add +1 or -1
   assign nxt_total = moving ? cur_total + {{(DATA_W-1){~up}}, 1'b1} : cur_total;
   assign nxt_tally = bad ? cur_tally + DATA_W'(1) : cur_tally;
   assign nxt_stamp = moving ? item.time_us : cur_stamp;

   always_comb begin
      result = '0;
      if (in_range) begin
         result.step           = moving ? (up ? 2'sb01 : 2'sb11) : 2'sb00;
         result.invalid        = bad;
         result.position       = nxt_total;
         result.reject_count   = nxt_tally;
         result.last_edge_time = nxt_stamp;
      end
   end

   always_comb begin
      for (int k = 0; k < KNOBS; k++) begin
         ab_in[k]    = ab_ff[k];
         total_in[k] = total_ff[k];
         tally_in[k] = tally_ff[k];
         stamp_in[k] = stamp_ff[k];
         if (fire && hit[k]) begin
            ab_in[k]    = now_ab;
            total_in[k] = nxt_total;
            tally_in[k] = nxt_tally;
            stamp_in[k] = nxt_stamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < KNOBS; k++) begin
         if (reset) begin
            ab_ff[k]    <= AB_RESET;
            total_ff[k] <= '0;
            tally_ff[k] <= '0;
            stamp_ff[k] <= '0;
         end else begin
            ab_ff[k]    <= ab_in[k];
            total_ff[k] <= total_in[k];
            tally_ff[k] <= tally_in[k];
            stamp_ff[k] <= stamp_in[k];
         end
      end
   end

endmodule

/* sv/multi_knob_quadrature_decoder_top.sv */
// Top level of the multi-knob quadrature decoder: input register, config
// register, response register around qdec_core. Depends on qdec_pkg, qdec_core.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | req_item (req_type)
//   rsp     | out       | rsp_valid/rsp_stall | rsp_item (rsp_type)
//   csr     | in        | csr_wr_en           | csr_wr_data (reverse mask)
//
// One item per cycle sustained while rsp_stall stays low; an accepted request
// passes the input register and then the response register before rsp_valid rises.
// The decode and state update sit between the input and response registers.
// Reset is synchronous and returns every knob to AB = both high, counters zero.
// A stalled response holds; the input register still drains into an empty
// or departing response register.
module multi_knob_quadrature_decoder_top #(
   parameter int KNOBS = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  qdec_pkg::req_type           req_item,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output qdec_pkg::rsp_type           rsp_item,
   input  logic                        csr_wr_en,
   input  logic [qdec_pkg::MASK_W-1:0] csr_wr_data
);
   import qdec_pkg::*;

   logic              in_valid_ff;
   logic              in_valid_in;
   req_type           in_item_ff;
   logic              out_valid_ff;
   logic              out_valid_in;
   rsp_type           out_item_ff;
   logic [MASK_W-1:0] mask_ff;
   logic              advance;
   logic              req_accept;
   rsp_type           core_result;

   assign advance     = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign req_accept  = req_valid && !req_stall;
   assign in_valid_in = req_accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   qdec_core #(.KNOBS(KNOBS)) u_core (
      .clock        (clock),
      .reset        (reset),
      .fire         (advance),
      .item         (in_item_ff),
      .reverse_mask (mask_ff),
      .result       (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mask_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            mask_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_item_ff <= core_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule

/* sv/qdec_checker.sv */
// Port-level checks for the multi-knob quadrature decoder, bound to the top.
// Depends on qdec_pkg and multi_knob_quadrature_decoder_top.
module qdec_props (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input qdec_pkg::rsp_type rsp_item
);
   import qdec_pkg::*;

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("stalled response changed");

   a_invalid_no_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.invalid |-> rsp_item.step == 2'sb00)
      else $error("rejected jump carries a step");

   a_step_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.step != 2'sb10)
      else $error("step outside -1..1");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind multi_knob_quadrature_decoder_top qdec_props u_qdec_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);
